// File: design/flocking_separation_steer_assert.svh
// Assertion macros used by the checker file.
`ifndef FLOCKING_SEPARATION_STEER_ASSERT_SVH
`define FLOCKING_SEPARATION_STEER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/fss_pkg.sv
package fss_pkg;

   localparam int POS_W = 24;
   localparam int DIFF_W = 25;
   localparam int SUM_W = 28;
   localparam int DIR_W = 18;
   localparam int RAD_W = 23;
   localparam int MAG_W = 28;
   localparam int PROD_W = 56;
   localparam int SQ_W = 58;
   localparam int ROOT_W = 59;
   localparam int LEN_W = 30;
   localparam int QUO_W = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd4096;

   // One classified neighbour transaction between front and back.
   typedef struct packed {
      logic signed [DIFF_W-1:0] d_x;
      logic signed [DIFF_W-1:0] d_y;
      logic signed [DIFF_W-1:0] d_z;
      logic is_self;
      logic last;
   } fss_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DSQ,
      ST_DTEST,
      ST_NORM,
      ST_USQ,
      ST_SQRT,
      ST_DIV,
      ST_ACC,
      ST_LAST,
      ST_OUT
   } fss_state_type;

endpackage

// File: design/fss_front.sv
module fss_front import fss_pkg::*; (
   input  logic [143:0] req_tdata,
   input  logic req_tuser,
   input  logic req_tlast,
   output fss_entry_type entry
);

   logic signed [POS_W-1:0] self_x, self_y, self_z;
   logic signed [POS_W-1:0] other_x, other_y, other_z;

   // Unpack positions
   assign self_x = req_tdata[23:0];
   assign self_y = req_tdata[47:24];
   assign self_z = req_tdata[71:48];
   assign other_x = req_tdata[95:72];
   assign other_y = req_tdata[119:96];
   assign other_z = req_tdata[143:120];

   // Offset toward the neighbour, exact in 25 bits
   always_comb begin
      entry.d_x = DIFF_W'(other_x) - DIFF_W'(self_x);
      entry.d_y = DIFF_W'(other_y) - DIFF_W'(self_y);
      entry.d_z = DIFF_W'(other_z) - DIFF_W'(self_z);
      entry.is_self = req_tuser;
      entry.last = req_tlast;
   end

endmodule

// File: design/fss_queue.sv
module fss_queue import fss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic wr_ready,
   input  fss_entry_type wr_data,
   output logic rd_valid,
   input  logic rd_pop,
   output fss_entry_type rd_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   fss_entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic push, pop;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign push = wr_valid & wr_ready;
   assign pop = rd_pop & rd_valid;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/fss_back.sv
module fss_back import fss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [RAD_W-1:0] radius,
   input  logic q_valid,
   output logic q_pop,
   input  fss_entry_type q_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata
);

   fss_state_type state_ff, state_in;

   logic [MAG_W-1:0] a_ff [3];
   logic neg_ff [3];
   logic last_ff, fin_ff;
   logic [2:0] cnt_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0] s_ff;
   logic [45:0] rsq_ff;
   logic [ROOT_W-1:0] res_ff, bit_ff;
   logic [28:0] rem_ff;
   logic [QUO_W-1:0] nlo_ff, q_ff;
   logic [4:0] dcnt_ff;
   logic [1:0] ci_ff;
   logic signed [DIR_W-1:0] dir_ff [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic rsp_tvalid_ff;
   logic [55:0] rsp_tdata_ff;

   logic [MAG_W-1:0] op, m_max;
   logic [ROOT_W-1:0] trial;
   logic [LEN_W-1:0] len;
   logic [44:0] numer;
   logic [29:0] dtry;
   logic qbit;
   logic [QUO_W-1:0] q_next;
   logic near_zero, in_range, out_load;

   // Squaring operand: stored magnitudes, then the radius
   always_comb begin
      if (cnt_ff < 3'd3) begin
         op = a_ff[cnt_ff[1:0]];
      end else begin
         op = MAG_W'(radius);
      end
   end

   // Largest magnitude for the normalize shift
   always_comb begin
      m_max = a_ff[0];
      if (a_ff[1] > m_max) m_max = a_ff[1];
      if (a_ff[2] > m_max) m_max = a_ff[2];
   end

   // Root step and divide step
   assign trial = res_ff + bit_ff;
   assign len = res_ff[LEN_W-1:0];
   assign numer = {1'b0, a_ff[ci_ff], 16'b0} + 45'(len >> 1);
   assign dtry = {rem_ff, nlo_ff[QUO_W-1]};
   assign qbit = (dtry >= len);
   assign q_next = {q_ff[QUO_W-2:0], qbit};

   always_comb begin
      near_zero = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!(sum_ff[i] == '0 || sum_ff[i] == SUM_W'(1) || sum_ff[i] == -SUM_W'(1))) begin
            near_zero = 1'b0;
         end
      end
   end

   assign in_range = (s_ff != '0) && (s_ff < SQ_W'(rsq_ff));

   // Control outputs
   always_comb begin
      q_pop = (state_ff == ST_IDLE) && q_valid;
      out_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = q_data.is_self ? ST_LAST : ST_DSQ;
         end
         ST_DSQ: begin
            if (cnt_ff == 3'd4) state_in = ST_DTEST;
         end
         ST_DTEST: begin
            state_in = in_range ? ST_NORM : ST_LAST;
         end
         ST_NORM: begin
            if (m_max[MAG_W-1] || m_max == '0) state_in = ST_USQ;
         end
         ST_USQ: begin
            if (cnt_ff == 3'd3) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (bit_ff == ROOT_W'(1)) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dcnt_ff == 5'(QUO_W) && ci_ff == 2'd2) state_in = fin_ff ? ST_OUT : ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_LAST;
         end
         ST_LAST: begin
            if (!last_ff) state_in = ST_IDLE;
            else state_in = near_zero ? ST_OUT : ST_NORM;
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      logic signed [SUM_W:0] acc;
      logic signed [DIFF_W-1:0] dv;
      if (reset) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !out_load) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  for (int i = 0; i < 3; i++) begin
                     dv = (i == 0) ? q_data.d_x : ((i == 1) ? q_data.d_y : q_data.d_z);
                     neg_ff[i] <= dv[DIFF_W-1];
                     a_ff[i] <= MAG_W'(dv[DIFF_W-1] ? -dv : dv);
                  end
                  last_ff <= q_data.last;
                  fin_ff <= 1'b0;
                  s_ff <= '0;
                  cnt_ff <= '0;
               end
            end
            ST_DSQ: begin
               prod_ff <= op * op;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff != 3'd0 && cnt_ff != 3'd4) s_ff <= s_ff + SQ_W'(prod_ff);
               if (cnt_ff == 3'd4) rsq_ff <= prod_ff[45:0];
            end
            ST_DTEST: begin
               cnt_ff <= '0;
            end
            ST_NORM: begin
               if (m_max[MAG_W-1] || m_max == '0) begin
                  cnt_ff <= '0;
                  s_ff <= '0;
               end else begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= {a_ff[i][MAG_W-2:0], 1'b0};
               end
            end
            ST_USQ: begin
               prod_ff <= op * op;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff != 3'd0) s_ff <= s_ff + SQ_W'(prod_ff);
               res_ff <= '0;
               bit_ff <= ROOT_W'(1) << (ROOT_W - 1);
            end
            ST_SQRT: begin
               if ({1'b0, s_ff} >= trial) begin
                  s_ff <= s_ff - trial[SQ_W-1:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               dcnt_ff <= '0;
               ci_ff <= '0;
            end
            ST_DIV: begin
               if (dcnt_ff == '0) begin
                  rem_ff <= 29'(numer[44:QUO_W]);
                  nlo_ff <= numer[QUO_W-1:0];
                  q_ff <= '0;
                  dcnt_ff <= 5'd1;
               end else begin
                  rem_ff <= qbit ? 29'(dtry - len) : dtry[28:0];
                  nlo_ff <= {nlo_ff[QUO_W-2:0], 1'b0};
                  q_ff <= q_next;
                  if (dcnt_ff == 5'(QUO_W)) begin
                     dir_ff[ci_ff] <= neg_ff[ci_ff] ? -DIR_W'(q_next) : DIR_W'(q_next);
                     ci_ff <= ci_ff + 1'b1;
                     dcnt_ff <= '0;
                  end else begin
                     dcnt_ff <= dcnt_ff + 1'b1;
                  end
               end
            end
            ST_ACC: begin
               for (int i = 0; i < 3; i++) begin
                  acc = (SUM_W+1)'(sum_ff[i]) - (SUM_W+1)'(dir_ff[i]);
                  if (acc[SUM_W] != acc[SUM_W-1]) begin
                     sum_ff[i] <= acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
                  end else begin
                     sum_ff[i] <= acc[SUM_W-1:0];
                  end
               end
            end
            ST_LAST: begin
               if (last_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= sum_ff[i][SUM_W-1];
                     a_ff[i] <= sum_ff[i][SUM_W-1] ? MAG_W'(-sum_ff[i]) : MAG_W'(sum_ff[i]);
                     dir_ff[i] <= DIR_W'(sum_ff[i]);
                  end
                  fin_ff <= 1'b1;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff <= {2'b0, dir_ff[2], dir_ff[1], dir_ff[0]};
                  for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

// File: design/flocking_separation_steer.sv
// Separation steering for one agent of a flock.
// req channel: one neighbour per transaction, with the agent's own position.
//   tdata holds self_x, self_y, self_z, other_x, other_y, other_z (signed Q12.12)
//   tuser is is_self (entry skipped), tlast marks the final neighbour of a run.
// rsp channel: one transaction per run, the unit steering direction in Q1.16.
// csr channel: writes the radius (unsigned Q11.12); ready is always high.
// Inputs go into a two-entry queue; a back-end sequencer then runs the
// distance test and a shared normalize unit (shift search, squares on one
// 28x28 multiplier, bit-serial square root, bit-serial divide per axis).
// A skipped or out-of-range neighbour bypasses the normalize unit; one that counts
// runs it, with the 30-step root and three 17-step divides. The last item of a run
// also normalizes the sum for the result unless every axis of the sum is within +/-1.
// The result waits in an output register; while the receiver stalls the back
// end holds in its output step and the queue keeps accepting until full.
// Reset is synchronous: the sum clears and the radius returns to 1.0.
module flocking_separation_steer import fss_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [143:0] req_tdata,  // self_x, self_y, self_z, other_x, other_y, other_z
   input  logic req_tuser,          // is_self
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,   // dir_x, dir_y, dir_z, 2 zero bits
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [RAD_W-1:0] csr_data
);

   fss_entry_type front_entry, q_data;
   logic q_valid, q_pop;
   logic [RAD_W-1:0] radius_ff;

   // Radius register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   fss_front u_front (
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .entry(front_entry)
   );

   fss_queue u_queue (
      .clock(clock),
      .reset(reset),
      .wr_valid(req_tvalid),
      .wr_ready(req_tready),
      .wr_data(front_entry),
      .rd_valid(q_valid),
      .rd_pop(q_pop),
      .rd_data(q_data)
   );

   fss_back u_back (
      .clock(clock),
      .reset(reset),
      .radius(radius_ff),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_data(q_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule

// File: design/fss_checker.sv
`include "flocking_separation_steer_assert.svh"

module fss_checker import fss_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [143:0] req_tdata,
   input logic req_tuser,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic csr_valid,
   input logic csr_ready,
   input logic [RAD_W-1:0] csr_data
);

   logic signed [DIR_W-1:0] dx, dy, dz;
   logic dir_ok;
   assign dx = rsp_tdata[17:0];
   assign dy = rsp_tdata[35:18];
   assign dz = rsp_tdata[53:36];
   assign dir_ok = (dx >= -18'sd65536) && (dx <= 18'sd65536) &&
                   (dy >= -18'sd65536) && (dy <= 18'sd65536) &&
                   (dz >= -18'sd65536) && (dz <= 18'sd65536);

   // A stalled result holds
   `FSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Directions stay within the unit range
   `FSS_ASSERT_NOW(a_dir_range, clock, reset, rsp_tvalid, dir_ok, "direction out of range")

   // Padding bits of a result are zero
   `FSS_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[55:54] == 2'b00, "result padding not zero")

endmodule

bind flocking_separation_steer fss_checker u_fss_checker (.*);

// File: test/flocking_separation_steer_test.sv
`timescale 1ns / 1ps

module flocking_separation_steer_test;
   import fss_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam longint SUM_HI = (64'sd1 <<< 27) - 1;
   localparam longint SUM_LO = -(64'sd1 <<< 27);
   localparam int RAD_MAX = (1 << RAD_W) - 1;

   // Predicts steering directions and checks them against the block's results.
   class steer_scoreboard;
      longint sum_v[3];
      longint unsigned radius_q;
      bit [53:0] dir_fifo[$];
      int errors;
      int results;
      int neighbours_counted;

      function new();
         radius_q = RADIUS_RESET;
         foreach (sum_v[i]) sum_v[i] = 0;
         errors = 0;
         results = 0;
         neighbours_counted = 0;
      endfunction

      function int pending();
         return dir_fifo.size();
      endfunction

      // floor(sqrt(x)), digit by digit
      function longint unsigned root_floor(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Unit vector in Q1.16, half away from zero; zero vector stays zero.
      function void unit_vec(input longint v[3], output longint u[3]);
         longint unsigned a[3], m, s, len, q;
         int k;
         m = 0;
         for (int i = 0; i < 3; i++) begin
            a[i] = (v[i] < 0) ? -v[i] : v[i];
            if (a[i] > m) m = a[i];
         end
         if (m == 0) begin
            foreach (u[i]) u[i] = 0;
            return;
         end
         k = 0;
         while ((m << k) < (64'd1 << 27)) k++;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            a[i] = a[i] << k;
            s += a[i] * a[i];
         end
         len = root_floor(s);
         for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 16) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
      endfunction

      // Accepted neighbour transaction.
      function void note_neighbour(bit [143:0] data, bit is_self, bit last);
         longint d[3], u[3], r[3], t;
         longint unsigned dist_sq;
         logic signed [23:0] sp, op;
         bit big;
         if (!is_self) begin
            dist_sq = 0;
            for (int i = 0; i < 3; i++) begin
               sp = data[24*i +: 24];
               op = data[72 + 24*i +: 24];
               d[i] = longint'(op) - longint'(sp);
               dist_sq += d[i] * d[i];
            end
            if (dist_sq != 0 && dist_sq < radius_q * radius_q) begin
               unit_vec(d, u);
               neighbours_counted++;
               for (int i = 0; i < 3; i++) begin
                  t = sum_v[i] - u[i];
                  sum_v[i] = (t > SUM_HI) ? SUM_HI : (t < SUM_LO) ? SUM_LO : t;
               end
            end
         end
         if (last) begin
            big = 0;
            foreach (sum_v[i]) if (sum_v[i] > 1 || sum_v[i] < -1) big = 1;
            if (big) unit_vec(sum_v, r);
            else foreach (r[i]) r[i] = sum_v[i];
            dir_fifo.push_back({r[2][17:0], r[1][17:0], r[0][17:0]});
            foreach (sum_v[i]) sum_v[i] = 0;
         end
      endfunction

      // Accepted result transaction.
      function void check_dir(bit [55:0] data);
         bit [53:0] want;
         if (dir_fifo.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, data);
            errors++;
            return;
         end
         want = dir_fifo.pop_front();
         results++;
         for (int i = 0; i < 3; i++)
            if (data[18*i +: 18] !== want[18*i +: 18]) begin
               $display("%0t: dir axis %0d mismatch, expected %0d actual %0d", $time, i,
                        $signed(want[18*i +: 18]), $signed(data[18*i +: 18]));
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic req_tuser = 0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [RAD_W-1:0] csr_data = '0;

   steer_scoreboard sb = new();
   int cycles = 0;
   int hold_req = 0;
   int hold_left = 0;
   bit quiet = 0;
   int items_sent = 0;

   flocking_separation_steer u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[flocking_separation_steer] ERROR");
         $finish;
      end
   end

   // result side: random backpressure, plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_req > 0) begin
         hold_left <= hold_req;
         hold_req = 0;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (quiet) begin
         rsp_tready <= 1;
      end else if ($urandom_range(0, 299) == 0) begin
         hold_left <= $urandom_range(20, 100);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_dir(rsp_tdata);

   function automatic int gap_len();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic bit [143:0] pack_pos(int sx, int sy, int sz, int ox, int oy, int oz);
      bit [23:0] f[6];
      f = '{sx[23:0], sy[23:0], sz[23:0], ox[23:0], oy[23:0], oz[23:0]};
      return {f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   // Neighbour around a random agent, offsets within about +/- r per axis.
   function automatic bit [143:0] near_pos(int r);
      int s[3], o[3], span;
      span = (r > (1 << 22)) ? (1 << 22) : r;
      for (int i = 0; i < 3; i++) begin
         s[i] = int'($urandom());
         o[i] = s[i] + int'($urandom_range(0, 2 * span + 2)) - span - 1;
      end
      return pack_pos(s[0], s[1], s[2], o[0], o[1], o[2]);
   endfunction

   task automatic send(bit [143:0] data, bit is_self, bit last);
      int g;
      req_tvalid <= 1;
      req_tdata <= data;
      req_tuser <= is_self;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_neighbour(data, is_self, last);
      items_sent++;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic idle_sender();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_sender();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(int unsigned value);
      wait_drained();
      csr_valid <= 1;
      csr_data <= value[RAD_W-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.radius_q = value[RAD_W-1:0];
      csr_valid <= 0;
   endtask

   // Random runs: mostly close neighbours, some self entries and far noise.
   task automatic random_runs(int count, int r);
      int len, p;
      bit [143:0] d;
      for (int n = 0; n < count; ) begin
         len = $urandom_range(1, 8);
         for (int j = 0; j < len && n < count; j++, n++) begin
            p = $urandom_range(0, 99);
            d = (p < 12) ? pack_pos(int'($urandom()), int'($urandom()), int'($urandom()),
                                    int'($urandom()), int'($urandom()), int'($urandom()))
                         : near_pos(r);
            send(d, (p >= 12 && p < 20), (j == len - 1) || (n == count - 1));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed cases at the reset radius of 1.0
      send(pack_pos(0, 0, 0, 2048, 0, 0), 0, 1);
      send(pack_pos(0, 0, 0, 1000, 1000, 1000), 0, 0);
      send(pack_pos(5, 5, 5, 6, 5, 5), 0, 1);
      // extreme positions: far apart, then coincident
      send(pack_pos(8388607, 8388607, 8388607, -8388608, -8388608, -8388608), 0, 1);
      send(pack_pos(-8388608, 0, 8388607, -8388608, 0, 8388607), 0, 1);
      // coincident neighbour, then a lone one on the far side
      send(pack_pos(123, -77, 900, 123, -77, 900), 0, 0);
      send(pack_pos(0, 0, 0, 0, -3000, 0), 0, 1);
      // neighbours cancel: zero sum emitted unchanged
      send(pack_pos(0, 0, 0, 100, 0, 0), 0, 0);
      send(pack_pos(0, 0, 0, -100, 0, 0), 0, 1);
      // self entry on the last item still emits and clears
      send(pack_pos(10, 20, 30, 10, 20, 300), 0, 0);
      send(pack_pos(-8388608, 8388607, 0, 0, 0, 0), 1, 1);
      send(pack_pos(0, 0, 0, 0, 0, 0), 1, 1);
      // radius boundary: exactly 1.0 away does not count
      send(pack_pos(0, 0, 0, 4096, 0, 0), 0, 0);
      send(pack_pos(0, 0, 0, 0, 4095, 0), 0, 1);
      send(pack_pos(0, 0, 0, -1, 1, -1), 0, 1);
      send(pack_pos(8388607, -8388608, 0, 8388606, -8388607, 1), 0, 1);

      quiet = 1;
      random_runs(40, 4096);
      quiet = 0;
      random_runs(50, 6000);

      // nothing counts at radius 0
      write_radius(0);
      random_runs(20, 50);
      write_radius(1);
      random_runs(20, 2);
      write_radius(RAD_MAX);
      send(pack_pos(8388607, 8388607, 8388607, -8388608, -8388608, -8388608), 0, 1);
      random_runs(30, RAD_MAX);
      write_radius($urandom_range(1, RAD_MAX));
      random_runs(30, int'(sb.radius_q));

      // receiver holds off while every item closes a run: queue fills up
      write_radius(5000);
      hold_req = 600;
      quiet = 1;
      for (int i = 0; i < 40; i++) send(near_pos(5000), 0, 1);
      quiet = 0;
      wait_drained();

      // long run in one direction builds up a large sum
      for (int i = 0; i < 100; i++) send(pack_pos(7, 7, 7, 107, 7, 7), 0, i == 99);

      write_radius(RADIUS_RESET);
      random_runs(40, 4096);

      wait_drained();
      $display("sent %0d neighbours, %0d counted, %0d directions checked", items_sent,
               sb.neighbours_counted, sb.results);
      $display("radius settings 0, 1, 1.0, max and random; backpressure and a long run");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[flocking_separation_steer] OK");
      end else begin
         $display("[flocking_separation_steer] ERROR");
      end
      $finish;
   end

endmodule
